// ===== rtl/ctrv_pkg.sv =====
// Shared types, constants and the arctangent table of the CTRV pose predictor.
// Used by the rotation cell, the divider cell and the top level; no dependencies.
package ctrv_pkg;

  // Rotation and arithmetic widths
  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int ATAN_ENTRIES        = 24;
  localparam int ROT_W               = 32;
  localparam int ANG_W               = 33;
  localparam int TRIG_W              = 30;
  localparam int QUOT_W              = 34;
  localparam int NUM_W               = 63;
  localparam int DEN_W               = 47;
  localparam int THR_W               = 23;

  localparam logic [THR_W-1:0]        THR_RESET   = 23'd334;
  localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 32'sd163008219;
  localparam logic signed [TRIG_W-1:0] ONE_Q28    = 30'sd268435456;
  localparam logic [23:0]             PI_Q22      = 24'd13176795;
  localparam logic signed [ANG_W-1:0] PI_ANG      = 33'sh080000000;

  // One vector of the rotator and its residual angle (2^31 stands for pi).
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ANG_W-1:0] a;
  } rot_t;

  // Partial remainder and quotient bits of one long division.
  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [QUOT_W-1:0] quo;
  } quot_t;

  // Arctangent of 2^-i in angle units where 2^31 stands for pi.
  function automatic logic signed [ANG_W-1:0] atan_at(input int unsigned i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:       r = 33'sh020000000;
      1:       r = 33'sh012E4051E;
      2:       r = 33'sh009FB385B;
      3:       r = 33'sh0051111D4;
      4:       r = 33'sh0028B0D43;
      5:       r = 33'sh00145D7E1;
      6:       r = 33'sh000A2F61E;
      7:       r = 33'sh000517C55;
      8:       r = 33'sh00028BE53;
      9:       r = 33'sh000145F2F;
      10:      r = 33'sh0000A2F98;
      11:      r = 33'sh0000517CC;
      12:      r = 33'sh000028BE6;
      13:      r = 33'sh0000145F3;
      14:      r = 33'sh00000A2FA;
      15:      r = 33'sh00000517D;
      16:      r = 33'sh0000028BE;
      17:      r = 33'sh00000145F;
      18:      r = 33'sh000000A30;
      19:      r = 33'sh000000518;
      20:      r = 33'sh00000028C;
      21:      r = 33'sh000000146;
      22:      r = 33'sh0000000A3;
      23:      r = 33'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ctrv_cordic_cell.sv =====
// One rotation step of the sine/cosine chain, applied to two vectors at once.
// Depends on ctrv_pkg for the vector type and the arctangent table.
module ctrv_cordic_cell import ctrv_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic clk,
  input  logic en,
  input  rot_t a_in,
  input  rot_t b_in,
  output rot_t a_out,
  output rot_t b_out
);

  localparam logic signed [ANG_W-1:0] ANGLE = atan_at(STEP);

  // Rotate toward zero residual angle by atan(2^-STEP).
  function automatic rot_t turn(input rot_t r);
    logic signed [ROT_W-1:0] xs;
    logic signed [ROT_W-1:0] ys;
    rot_t o;
    xs = $signed(r.x) >>> STEP;
    ys = $signed(r.y) >>> STEP;
    if (!r.a[ANG_W-1]) begin
      o.x = $signed(r.x) - ys;
      o.y = $signed(r.y) + xs;
      o.a = $signed(r.a) - ANGLE;
    end else begin
      o.x = $signed(r.x) + ys;
      o.y = $signed(r.y) - xs;
      o.a = $signed(r.a) + ANGLE;
    end
    return o;
  endfunction

  // Hand the rotated vectors to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      a_out <= turn(a_in);
      b_out <= turn(b_in);
    end
  end

endmodule

// ===== rtl/ctrv_div_cell.sv =====
// One quotient bit of the restoring divider, for the x and y numerators at once.
// Depends on ctrv_pkg for the remainder type and the widths.
module ctrv_div_cell import ctrv_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] den,
  input  quot_t            x_in,
  input  quot_t            y_in,
  output quot_t            x_out,
  output quot_t            y_out
);

  localparam int CMP_W = DEN_W + QUOT_W;

  // Subtract the shifted divisor where it fits and record the quotient bit.
  function automatic quot_t settle(input quot_t q, input logic [DEN_W-1:0] d);
    logic [CMP_W-1:0] sh;
    logic [CMP_W-1:0] r;
    quot_t o;
    sh = CMP_W'(d) << BIT;
    r  = CMP_W'(q.rem);
    o  = q;
    if (r >= sh) begin
      o.rem      = NUM_W'(r - sh);
      o.quo[BIT] = 1'b1;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= settle(x_in, den);
      y_out <= settle(y_in, den);
    end
  end

endmodule

// ===== rtl/ctrv_pose_predict.sv =====
// Top level of the CTRV pose predictor: input stages, rotation chain, divider chain, output.
// Depends on ctrv_pkg, ctrv_cordic_cell and ctrv_div_cell.
//
// Usage: each input word (speed, turn_rate, step_time, pos_x, pos_y, heading) is taken
// when item_valid and item_ready are both high; one result word (next_x, next_y,
// next_heading) is offered on result_valid/result_ready for each input word, in order.
// The straight-motion threshold is written through cfg_write_en/cfg_write_data while
// the block is idle; it takes effect for words accepted afterwards.
// Pipeline: one rotation cell per iteration and one divider cell per quotient bit
// (34), plus six arithmetic and output stages, the first of which loads when its
// word is accepted.
// Throughput: one word per cycle while item_ready is high; the chain advances together.
// A stalled receiver: the output register and a one-word skid register absorb the
// word in flight; item_ready then drops until the skid register drains.
// Reset (synchronous, rst high) empties the pipeline and the output, and loads the
// threshold with 334.
module ctrv_pose_predict import ctrv_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [THR_W-1:0]    cfg_write_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic signed [19:0]  speed,
  input  logic signed [23:0]  turn_rate,
  input  logic [15:0]         step_time,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [15:0]  heading,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [31:0]  next_x,
  output logic signed [31:0]  next_y,
  output logic signed [15:0]  next_heading
);

  localparam int NS    = TRIG_ITERATIONS;
  localparam int L     = NS + 5 + QUOT_W;
  localparam int CMP_W = DEN_W + QUOT_W;

  // Word fields that travel beside the rotation chain.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] h2;
    logic signed [19:0] v;
    logic signed [35:0] vdt;
    logic               wneg;
    logic [DEN_W-1:0]   den;
    logic               straight;
    logic               flip1;
    logic               flip2;
  } cpay_t;

  // Word fields that travel beside the divider chain.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] h2;
    logic               straight;
    logic [DEN_W-1:0]   den;
    logic signed [21:0] sdx;
    logic signed [21:0] sdy;
    logic               negx;
    logic               negy;
    logic               ovfx;
    logic               ovfy;
  } dpay_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] h;
  } res_t;

  logic [THR_W-1:0] thr;
  logic             adv;
  logic [L-1:0]     vld;
  logic             fin_vld;
  logic             skid_vld;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_write_en) begin
      thr <= cfg_write_data;
    end
  end

  // Valid bits of all stages move together whenever the skid register is empty.
  assign adv        = !skid_vld;
  assign item_ready = adv;
  assign fin_vld    = vld[L-1] && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], item_valid};
    end
  end

  // Stage 0: products of the raw input word.
  logic signed [16:0] dt_s;
  logic [23:0]        abs_w;
  logic signed [40:0] wdt_full;
  logic signed [36:0] vdt_full;
  logic [47:0]        den_full;

  assign dt_s     = $signed({1'b0, step_time});
  assign abs_w    = turn_rate[23] ? 24'(-turn_rate) : 24'(turn_rate);
  assign wdt_full = turn_rate * dt_s;
  assign vdt_full = speed * dt_s;
  assign den_full = abs_w * PI_Q22;

  logic signed [19:0] s0_v;
  logic signed [15:0] s0_h;
  logic signed [31:0] s0_px;
  logic signed [31:0] s0_py;
  logic signed [39:0] s0_wdt;
  logic signed [35:0] s0_vdt;
  logic               s0_straight;
  logic               s0_wneg;
  logic [DEN_W-1:0]   s0_den;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_v        <= speed;
      s0_h        <= heading;
      s0_px       <= pos_x;
      s0_py       <= pos_y;
      s0_wdt      <= wdt_full[39:0];
      s0_vdt      <= vdt_full[35:0];
      s0_straight <= (turn_rate == '0) || (abs_w < {1'b0, thr});
      s0_wneg     <= turn_rate[23];
      s0_den      <= den_full[DEN_W-1:0];
    end
  end

  // Stage 1: new heading and start vectors for both rotations.
  function automatic logic needs_flip(input logic signed [15:0] hh);
    return (hh > 16'sd16384) || (hh < -16'sd16384);
  endfunction

  function automatic rot_t start_vec(input logic signed [15:0] hh);
    logic signed [ANG_W-1:0] a;
    rot_t o;
    a = $signed({hh[15], hh, 16'b0});
    if (hh > 16'sd16384) begin
      a = a - PI_ANG;
    end else if (hh < -16'sd16384) begin
      a = a + PI_ANG;
    end
    o.x = CORDIC_GAIN;
    o.y = '0;
    o.a = a;
    return o;
  endfunction

  logic signed [39:0] d_sum;
  logic signed [15:0] h2_c;

  assign d_sum = s0_wdt + 40'sd1048576;
  assign h2_c  = s0_h + $signed(d_sum[36:21]);

  rot_t  rot_a [0:NS];
  rot_t  rot_b [0:NS];
  cpay_t cpay  [0:NS];

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_a[0]         <= start_vec(s0_h);
      rot_b[0]         <= start_vec(h2_c);
      cpay[0].px       <= s0_px;
      cpay[0].py       <= s0_py;
      cpay[0].h2       <= h2_c;
      cpay[0].v        <= s0_v;
      cpay[0].vdt      <= s0_vdt;
      cpay[0].wneg     <= s0_wneg;
      cpay[0].den      <= s0_den;
      cpay[0].straight <= s0_straight;
      cpay[0].flip1    <= needs_flip(s0_h);
      cpay[0].flip2    <= needs_flip(h2_c);
    end
  end

  // Rotation chain: one cell per iteration.
  for (genvar k = 0; k < NS; k++) begin : g_rot
    ctrv_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk  (clk),
      .en   (adv),
      .a_in (rot_a[k]),
      .b_in (rot_b[k]),
      .a_out(rot_a[k+1]),
      .b_out(rot_b[k+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        cpay[k+1] <= cpay[k];
      end
    end
  end

  // Post stage 1: undo the half-turn and clamp to one.
  function automatic logic signed [TRIG_W-1:0] fold(input logic signed [ROT_W-1:0] v,
                                                    input logic flip);
    logic signed [ROT_W-1:0] t;
    logic signed [TRIG_W-1:0] r;
    t = flip ? -v : v;
    if (t > ROT_W'(ONE_Q28)) begin
      r = ONE_Q28;
    end else if (t < -ROT_W'(ONE_Q28)) begin
      r = -ONE_Q28;
    end else begin
      r = t[TRIG_W-1:0];
    end
    return r;
  endfunction

  cpay_t                    p1_pay;
  logic signed [TRIG_W-1:0] p1_c1;
  logic signed [TRIG_W-1:0] p1_s1;
  logic signed [TRIG_W-1:0] p1_c2;
  logic signed [TRIG_W-1:0] p1_s2;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_pay <= cpay[NS];
      p1_c1  <= fold(rot_a[NS].x, cpay[NS].flip1);
      p1_s1  <= fold(rot_a[NS].y, cpay[NS].flip1);
      p1_c2  <= fold(rot_b[NS].x, cpay[NS].flip2);
      p1_s2  <= fold(rot_b[NS].y, cpay[NS].flip2);
    end
  end

  // Post stage 2: straight-line and arc numerator products.
  logic signed [TRIG_W:0] dsin;
  logic signed [TRIG_W:0] dcos;

  assign dsin = p1_s2 - p1_s1;
  assign dcos = p1_c1 - p1_c2;

  cpay_t              p2_pay;
  logic signed [65:0] p2_sx;
  logic signed [65:0] p2_sy;
  logic signed [50:0] p2_ax;
  logic signed [50:0] p2_ay;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_pay <= p1_pay;
      p2_sx  <= $signed(p1_pay.vdt) * p1_c1;
      p2_sy  <= $signed(p1_pay.vdt) * p1_s1;
      p2_ax  <= $signed(p1_pay.v) * dsin;
      p2_ay  <= $signed(p1_pay.v) * dcos;
    end
  end

  // Post stage 3: rounding of the straight step, divider operands and overflow.
  logic signed [65:0] sx_rnd;
  logic signed [65:0] sy_rnd;
  logic [50:0]        magx;
  logic [50:0]        magy;
  logic [NUM_W-1:0]   numx;
  logic [NUM_W-1:0]   numy;
  logic [CMP_W-1:0]   den_top;

  assign sx_rnd  = p2_sx + 66'sd8796093022208;
  assign sy_rnd  = p2_sy + 66'sd8796093022208;
  assign magx    = p2_ax[50] ? 51'(-p2_ax) : 51'(p2_ax);
  assign magy    = p2_ay[50] ? 51'(-p2_ay) : 51'(p2_ay);
  assign numx    = {magx[48:0], 14'b0} + NUM_W'(p2_pay.den >> 1);
  assign numy    = {magy[48:0], 14'b0} + NUM_W'(p2_pay.den >> 1);
  assign den_top = {p2_pay.den, {QUOT_W{1'b0}}};

  quot_t qx   [0:QUOT_W];
  quot_t qy   [0:QUOT_W];
  dpay_t dpay [0:QUOT_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      qx[0].rem         <= numx;
      qx[0].quo         <= '0;
      qy[0].rem         <= numy;
      qy[0].quo         <= '0;
      dpay[0].px        <= p2_pay.px;
      dpay[0].py        <= p2_pay.py;
      dpay[0].h2        <= p2_pay.h2;
      dpay[0].straight  <= p2_pay.straight;
      dpay[0].den       <= p2_pay.den;
      dpay[0].sdx       <= sx_rnd[65:44];
      dpay[0].sdy       <= sy_rnd[65:44];
      dpay[0].negx      <= p2_ax[50] ^ p2_pay.wneg;
      dpay[0].negy      <= p2_ay[50] ^ p2_pay.wneg;
      dpay[0].ovfx      <= CMP_W'(numx) >= den_top;
      dpay[0].ovfy      <= CMP_W'(numy) >= den_top;
    end
  end

  // Divider chain: one cell per quotient bit, most significant first.
  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    ctrv_div_cell #(
      .BIT(QUOT_W - 1 - j)
    ) u_cell (
      .clk  (clk),
      .en   (adv),
      .den  (dpay[j].den),
      .x_in (qx[j]),
      .y_in (qy[j]),
      .x_out(qx[j+1]),
      .y_out(qy[j+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        dpay[j+1] <= dpay[j];
      end
    end
  end

  // Final step: pick the motion, add to the position and saturate.
  function automatic logic signed [31:0] place(input logic signed [31:0] p,
                                               input logic straight,
                                               input logic signed [21:0] sd,
                                               input logic neg,
                                               input logic ovf,
                                               input logic [QUOT_W-1:0] quo);
    logic [QUOT_W:0]          mag;
    logic signed [QUOT_W+1:0] arc;
    logic signed [QUOT_W+1:0] dlt;
    logic signed [QUOT_W+2:0] sum;
    logic signed [31:0]       r;
    mag = ovf ? ((QUOT_W+1)'(1) << QUOT_W) : {1'b0, quo};
    arc = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    dlt = straight ? (QUOT_W+2)'(sd) : arc;
    sum = (QUOT_W+3)'(p) + (QUOT_W+3)'(dlt);
    if ((sum[QUOT_W+2:31] == '0) || (sum[QUOT_W+2:31] == '1)) begin
      r = sum[31:0];
    end else if (sum[QUOT_W+2]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7FFFFFFF;
    end
    return r;
  endfunction

  res_t fin;

  assign fin.x = place(dpay[QUOT_W].px, dpay[QUOT_W].straight, dpay[QUOT_W].sdx,
                       dpay[QUOT_W].negx, dpay[QUOT_W].ovfx, qx[QUOT_W].quo);
  assign fin.y = place(dpay[QUOT_W].py, dpay[QUOT_W].straight, dpay[QUOT_W].sdy,
                       dpay[QUOT_W].negy, dpay[QUOT_W].ovfy, qy[QUOT_W].quo);
  assign fin.h = dpay[QUOT_W].h2;

  // Output register with a one-word skid register behind it.
  res_t out_word;
  res_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_vld     <= 1'b0;
    end else if (result_valid && !result_ready) begin
      if (fin_vld) begin
        skid_vld <= 1'b1;
        skid     <= fin;
      end
    end else if (skid_vld) begin
      out_word     <= skid;
      result_valid <= 1'b1;
      skid_vld     <= 1'b0;
    end else begin
      result_valid <= fin_vld;
      if (fin_vld) begin
        out_word <= fin;
      end
    end
  end

  assign next_x       = out_word.x;
  assign next_y       = out_word.y;
  assign next_heading = out_word.h;

endmodule
